// File: sv/batc_pkg.sv
// Shared widths, reset values, codes and the saturation helper of the trend calibrator.
package batc_pkg;

    localparam int RAW_W      = 23;
    localparam int ELAP_W     = 32;
    localparam int SLOPE_W    = 17;
    localparam int OFFB_W     = 24;
    localparam int DB_W       = 16;
    localparam int BMS_W      = 32;
    localparam int MINC_W     = 16;
    localparam int VAL_W      = 25;
    localparam int LINE_W     = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = SLOPE_W + RAW_W;
    localparam int WORK_W     = 64;

    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [SLOPE_W-1:0]       RST_SLOPE_FALL = SLOPE_W'(63177);
    localparam logic signed [OFFB_W-1:0] RST_OFF_FALL   = OFFB_W'(80282);
    localparam logic [SLOPE_W-1:0]       RST_SLOPE_RISE = SLOPE_W'(69114);
    localparam logic [DB_W-1:0]          RST_DEAD_BAND  = DB_W'(131);
    localparam logic [BMS_W-1:0]         RST_BASE_MS    = BMS_W'(120000);
    localparam logic [MINC_W-1:0]        RST_MIN_CNT    = MINC_W'(10);

    localparam logic signed [WORK_W-1:0] SAT_HI = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
    localparam logic signed [WORK_W-1:0] SAT_LO = -(64'sd1 <<< (VAL_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOPE_FALL = 3'd0,
        CFG_OFF_FALL   = 3'd1,
        CFG_SLOPE_RISE = 3'd2,
        CFG_DEAD_BAND  = 3'd3,
        CFG_BASE_MS    = 3'd4,
        CFG_MIN_CNT    = 3'd5
    } t_cfg_idx;

    typedef enum logic [LINE_W-1:0] {
        LINE_BASE = 2'd0,
        LINE_FALL = 2'd1,
        LINE_RISE = 2'd2
    } t_line;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_ACC,
        S_DIVR_GO,
        S_DIVR_WAIT,
        S_DIVT_GO,
        S_DIVT_WAIT,
        S_ANCF_MUL,
        S_ANCF_ADD,
        S_ANCR_MUL,
        S_ANCR_ADD,
        S_DONE
    } t_state;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WORK_W-1:0] v);
        logic signed [VAL_W-1:0] res;
        priority if (v > SAT_HI) begin
            res = SAT_HI[VAL_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[VAL_W-1:0];
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: sv/batc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module batc_div #(
    parameter int DVD_W = 41,
    parameter int DVS_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   rem_sh;
    logic             fits;

    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        fits   = rem_sh >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W - 1);
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[DVD_W-2:0], fits};
            n_rem = fits ? DVS_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DVS_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    // divide by zero reads as zero
    assign o_done     = r_done;
    assign o_quotient = (r_dvs == '0) ? '0 : r_q;

endmodule

// File: sv/baseline_anchored_trend_calibrator_top.sv
// Top level of the baseline-anchored trend calibrator: sequencer, shared multiply/add, state.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: raw_sample, elapsed_ms
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: corrected, mean_raw, mean_true
//                                                tuser: line_used, locked_now
//  cfg       in   i_cfg_wr_en (no wait)          i_cfg_idx, i_cfg_data
//
// One item is taken at a time; s_axis_tready is high only while the sequencer is idle.
// A baseline sample passes through accept, multiply, add, accumulate and output load steps;
// a tracking sample skips the accumulate step. The locking sample adds two passes through
// the bit-serial divider of COUNT_BITS+25 steps each, and four multiply/add steps.
// The result sits in an output register; the sequencer waits in its last step only while
// that register still holds an untaken result. Synchronous active-low reset, no clear pass.
module baseline_anchored_trend_calibrator_top
    import batc_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [55:0]           s_axis_tdata,   // raw_sample[22:0], elapsed_ms[54:23]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [79:0]           m_axis_tdata,   // corrected[24:0], mean_raw[47:25],
                                                  // mean_true[72:48]
    output logic [2:0]            m_axis_tuser,   // line_used[1:0], locked_now[2]
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_R_W = RAW_W + COUNT_BITS;
    localparam int SUM_T_W = VAL_W + COUNT_BITS;
    localparam int CMP_W   = (COUNT_BITS > MINC_W) ? COUNT_BITS : MINC_W;
    localparam int OUT_PAD = 80 - (2 * VAL_W + RAW_W);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // configuration
    logic [SLOPE_W-1:0]       r_slope_fall, r_slope_rise;
    logic signed [OFFB_W-1:0] r_off_fall_base;
    logic [DB_W-1:0]          r_dead_band;
    logic [BMS_W-1:0]         r_base_ms;
    logic [MINC_W-1:0]        r_min_cnt;

    // sequencer and calibration state
    t_state                    r_state, n_state;
    logic                      r_phase, n_phase;
    logic                      r_trend, n_trend;
    logic                      r_lock, n_lock;
    logic [RAW_W-1:0]          r_last_raw, n_last_raw;
    logic [SUM_R_W-1:0]        r_sum_raw, n_sum_raw;
    logic signed [SUM_T_W-1:0] r_sum_true, n_sum_true;
    logic [COUNT_BITS-1:0]     r_cnt, n_cnt;
    logic signed [VAL_W-1:0]   r_off_fall, n_off_fall;
    logic signed [VAL_W-1:0]   r_off_rise, n_off_rise;
    logic [RAW_W-1:0]          r_base_raw, n_base_raw;
    logic signed [VAL_W-1:0]   r_base_true, n_base_true;
    logic                      r_m_valid, n_m_valid;

    // payload
    logic [RAW_W-1:0]        r_raw, n_raw;
    logic [ELAP_W-1:0]       r_elapsed, n_elapsed;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic signed [VAL_W-1:0] r_corr, n_corr;
    logic signed [VAL_W-1:0] r_o_corr, n_o_corr;
    t_line                   r_o_line, n_o_line;
    logic                    r_o_lock, n_o_lock;
    logic [RAW_W-1:0]        r_o_mraw, n_o_mraw;
    logic signed [VAL_W-1:0] r_o_mtrue, n_o_mtrue;

    // datapath
    logic                      s_acc, m_acc, out_load;
    logic [RAW_W-1:0]          in_raw;
    logic [ELAP_W-1:0]         in_elapsed;
    logic [RAW_W:0]            raw_lo, raw_hi, last_ext;
    logic [SLOPE_W-1:0]        mul_a;
    logic [RAW_W-1:0]          mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic signed [VAL_W-1:0]   add_op;
    logic                      add_neg;
    logic signed [WORK_W-1:0]  prod_w, op_w, sum_w;
    logic signed [VAL_W-1:0]   add_res;
    logic [COUNT_BITS-1:0]     cnt_next;
    logic                      lock_hit;
    logic                      div_start, div_done;
    logic [SUM_T_W-1:0]        div_dvd, div_q, true_mag;
    logic                      true_neg;
    logic signed [WORK_W-1:0]  q_w, true_q;

    assign in_raw     = s_axis_tdata[RAW_W-1:0];
    assign in_elapsed = s_axis_tdata[RAW_W+ELAP_W-1:RAW_W];
    assign s_acc      = s_axis_tvalid && (r_state == S_IDLE);
    assign m_acc      = r_m_valid && m_axis_tready;
    assign out_load   = !r_m_valid || m_axis_tready;

    // shared multiplier
    always_comb begin
        unique case (r_state)
            S_ANCF_MUL: begin
                mul_a = r_slope_fall;
                mul_b = r_base_raw;
            end
            S_ANCR_MUL: begin
                mul_a = r_slope_rise;
                mul_b = r_base_raw;
            end
            default: begin
                mul_a = (r_phase && r_trend) ? r_slope_rise : r_slope_fall;
                mul_b = r_raw;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // shared add/subtract with saturation: line value or anchored offset
    always_comb begin
        unique case (r_state)
            S_ANCF_ADD, S_ANCR_ADD: begin
                add_op  = r_base_true;
                add_neg = 1'b1;
            end
            default: begin
                add_neg = 1'b0;
                if (!r_phase) begin
                    add_op = VAL_W'(r_off_fall_base);
                end else begin
                    add_op = r_trend ? r_off_rise : r_off_fall;
                end
            end
        endcase
        prod_w  = $signed(WORK_W'(r_prod >> FRAC_BITS));
        op_w    = WORK_W'(add_op);
        sum_w   = add_neg ? (op_w - prod_w) : (op_w + prod_w);
        add_res = sat_val(sum_w);
    end

    // divider operands; the corrected sum is divided as a magnitude
    always_comb begin
        true_neg  = r_sum_true[SUM_T_W-1];
        true_mag  = true_neg ? SUM_T_W'(-r_sum_true) : SUM_T_W'(r_sum_true);
        div_start = (r_state == S_DIVR_GO) || (r_state == S_DIVT_GO);
        div_dvd   = (r_state == S_DIVR_GO) ? SUM_T_W'(r_sum_raw) : true_mag;
        q_w       = $signed(WORK_W'(div_q));
        true_q    = true_neg ? -q_w : q_w;
    end

    batc_div #(
        .DVD_W (SUM_T_W),
        .DVS_W (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // deadband compare on the incoming sample
    assign raw_lo   = {1'b0, in_raw} + (RAW_W + 1)'(r_dead_band);
    assign last_ext = {1'b0, r_last_raw};
    assign raw_hi   = last_ext + (RAW_W + 1)'(r_dead_band);

    assign cnt_next = (r_cnt != CNT_MAX) ? r_cnt + COUNT_BITS'(1) : r_cnt;
    assign lock_hit = (r_elapsed >= r_base_ms) && (CMP_W'(cnt_next) > CMP_W'(r_min_cnt));

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_trend     = r_trend;
        n_lock      = r_lock;
        n_last_raw  = r_last_raw;
        n_sum_raw   = r_sum_raw;
        n_sum_true  = r_sum_true;
        n_cnt       = r_cnt;
        n_off_fall  = r_off_fall;
        n_off_rise  = r_off_rise;
        n_base_raw  = r_base_raw;
        n_base_true = r_base_true;
        n_raw       = r_raw;
        n_elapsed   = r_elapsed;
        n_prod      = r_prod;
        n_corr      = r_corr;
        n_o_corr    = r_o_corr;
        n_o_line    = r_o_line;
        n_o_lock    = r_o_lock;
        n_o_mraw    = r_o_mraw;
        n_o_mtrue   = r_o_mtrue;
        n_m_valid   = m_acc ? 1'b0 : r_m_valid;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_raw     = in_raw;
                    n_elapsed = in_elapsed;
                    n_lock    = 1'b0;
                    if (r_phase) begin
                        // inside the band the previous trend is kept
                        if (raw_lo < last_ext) begin
                            n_trend = 1'b0;
                        end else if ({1'b0, in_raw} > raw_hi) begin
                            n_trend = 1'b1;
                        end
                        n_last_raw = in_raw;
                    end
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = mul_p;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_corr  = add_res;
                n_state = r_phase ? S_DONE : S_ACC;
            end
            S_ACC: begin
                if (r_cnt != CNT_MAX) begin
                    n_sum_raw  = r_sum_raw + SUM_R_W'(r_raw);
                    n_sum_true = r_sum_true + SUM_T_W'(r_corr);
                    n_cnt      = cnt_next;
                end
                n_lock  = lock_hit;
                n_state = lock_hit ? S_DIVR_GO : S_DONE;
            end
            S_DIVR_GO: begin
                n_state = S_DIVR_WAIT;
            end
            S_DIVR_WAIT: begin
                if (div_done) begin
                    n_base_raw = div_q[RAW_W-1:0];
                    n_state    = S_DIVT_GO;
                end
            end
            S_DIVT_GO: begin
                n_state = S_DIVT_WAIT;
            end
            S_DIVT_WAIT: begin
                if (div_done) begin
                    n_base_true = sat_val(true_q);
                    n_state     = S_ANCF_MUL;
                end
            end
            S_ANCF_MUL: begin
                n_prod  = mul_p;
                n_state = S_ANCF_ADD;
            end
            S_ANCF_ADD: begin
                n_off_fall = add_res;
                n_state    = S_ANCR_MUL;
            end
            S_ANCR_MUL: begin
                n_prod  = mul_p;
                n_state = S_ANCR_ADD;
            end
            S_ANCR_ADD: begin
                n_off_rise = add_res;
                n_phase    = 1'b1;
                n_trend    = 1'b0;
                n_last_raw = r_raw;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_m_valid = 1'b1;
                    n_o_corr  = r_corr;
                    n_o_lock  = r_lock;
                    if (r_lock || !r_phase) begin
                        n_o_line = LINE_BASE;
                    end else begin
                        n_o_line = r_trend ? LINE_RISE : LINE_FALL;
                    end
                    n_o_mraw  = r_phase ? r_base_raw : '0;
                    n_o_mtrue = r_phase ? r_base_true : '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope_fall    <= RST_SLOPE_FALL;
            r_off_fall_base <= RST_OFF_FALL;
            r_slope_rise    <= RST_SLOPE_RISE;
            r_dead_band     <= RST_DEAD_BAND;
            r_base_ms       <= RST_BASE_MS;
            r_min_cnt       <= RST_MIN_CNT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_SLOPE_FALL: r_slope_fall    <= i_cfg_data[SLOPE_W-1:0];
                CFG_OFF_FALL:   r_off_fall_base <= i_cfg_data[OFFB_W-1:0];
                CFG_SLOPE_RISE: r_slope_rise    <= i_cfg_data[SLOPE_W-1:0];
                CFG_DEAD_BAND:  r_dead_band     <= i_cfg_data[DB_W-1:0];
                CFG_BASE_MS:    r_base_ms       <= i_cfg_data[BMS_W-1:0];
                CFG_MIN_CNT:    r_min_cnt       <= i_cfg_data[MINC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_trend     <= 1'b0;
            r_lock      <= 1'b0;
            r_last_raw  <= '0;
            r_sum_raw   <= '0;
            r_sum_true  <= '0;
            r_cnt       <= '0;
            r_off_fall  <= '0;
            r_off_rise  <= '0;
            r_base_raw  <= '0;
            r_base_true <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_trend     <= n_trend;
            r_lock      <= n_lock;
            r_last_raw  <= n_last_raw;
            r_sum_raw   <= n_sum_raw;
            r_sum_true  <= n_sum_true;
            r_cnt       <= n_cnt;
            r_off_fall  <= n_off_fall;
            r_off_rise  <= n_off_rise;
            r_base_raw  <= n_base_raw;
            r_base_true <= n_base_true;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw     <= n_raw;
        r_elapsed <= n_elapsed;
        r_prod    <= n_prod;
        r_corr    <= n_corr;
        r_o_corr  <= n_o_corr;
        r_o_line  <= n_o_line;
        r_o_lock  <= n_o_lock;
        r_o_mraw  <= n_o_mraw;
        r_o_mtrue <= n_o_mtrue;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, r_o_mtrue, r_o_mraw, r_o_corr};
    assign m_axis_tuser  = {r_o_lock, r_o_line};

    // the locking item always reports the baseline line
    a_lock_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == LINE_BASE))
        else $error("locked item not on baseline line");

    // the dynamic phase begins only on an item that locked
    a_phase_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase) |-> r_lock)
        else $error("phase switched without lock");

    // divider completes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == S_DIVR_WAIT) || (r_state == S_DIVT_WAIT)))
        else $error("divider done outside wait step");

    // an accepted item goes straight to the multiply step
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == S_MUL))
        else $error("accepted item did not start");

endmodule

// File: sim/tb_baseline_anchored_trend_calibrator_top.sv
// Self-checking testbench for the baseline-anchored trend calibrator with its own predictor.
module tb_baseline_anchored_trend_calibrator_top;
    import batc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic [ELAP_W-1:0] ms;
    } t_sample;

    typedef struct packed {
        logic signed [VAL_W-1:0] corrected;
        t_line                   line;
        logic                    locked;
        logic [RAW_W-1:0]        mean_raw;
        logic signed [VAL_W-1:0] mean_true;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata = '0;   // raw_sample[22:0], elapsed_ms[54:23]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [79:0]           m_axis_tdata;        // corrected[24:0], mean_raw[47:25],
                                                // mean_true[72:48]
    logic [2:0]            m_axis_tuser;        // line_used[1:0], locked_now[2]
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    baseline_anchored_trend_calibrator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [SLOPE_W-1:0]       cfg_slope_fall = RST_SLOPE_FALL;
    logic signed [OFFB_W-1:0] cfg_off_base   = RST_OFF_FALL;
    logic [SLOPE_W-1:0]       cfg_slope_rise = RST_SLOPE_RISE;
    logic [DB_W-1:0]          cfg_band       = RST_DEAD_BAND;
    logic [BMS_W-1:0]         cfg_window_ms  = RST_BASE_MS;
    logic [MINC_W-1:0]        cfg_min_count  = RST_MIN_CNT;

    // predictor state
    bit                      tracking     = 1'b0;
    bit                      rising_trend = 1'b0;
    logic [RAW_W-1:0]        prev_raw     = '0;
    logic [38:0]             raw_total    = '0;
    logic signed [40:0]      true_total   = '0;
    logic [DEF_COUNT_BITS-1:0] n_counted  = '0;
    logic signed [VAL_W-1:0] fall_anchor  = '0;
    logic signed [VAL_W-1:0] rise_anchor  = '0;
    logic [RAW_W-1:0]        mean_raw_lk  = '0;
    logic signed [VAL_W-1:0] mean_true_lk = '0;

    t_sample  sample_q[$];
    t_reading reading_q[$];
    t_sample  cur_sample = '0;
    bit       sending = 1'b0;
    bit       calm = 1'b0;
    int       gap_left = 0;
    int       stall_left = 0;
    int       hold_left = 0;
    int       hold_reqs = 0;
    int       hold_seen = 0;
    int       cycle_count = 0;
    int       n_sent = 0;
    int       n_taken = 0;
    int       bad_results = 0;
    int       n_locks = 0;
    int       n_base = 0;
    int       n_fall = 0;
    int       n_rise = 0;
    logic [RAW_W-1:0] gen_raw = '0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_val(input logic signed [63:0] v);
        if (v > SAT_HI) return SAT_HI[VAL_W-1:0];
        if (v < SAT_LO) return SAT_LO[VAL_W-1:0];
        return v[VAL_W-1:0];
    endfunction

    // slope * raw >> FRAC, never negative
    function automatic logic signed [63:0] scaled(input logic [SLOPE_W-1:0] slope,
                                                  input logic [RAW_W-1:0] raw);
        logic [PROD_W-1:0] prod;
        prod = slope * raw;
        return $signed({{(64 - PROD_W){1'b0}}, prod >> DEF_FRAC_BITS});
    endfunction

    function automatic logic signed [VAL_W-1:0] on_line(input logic [SLOPE_W-1:0] slope,
                                                        input logic [RAW_W-1:0] raw,
                                                        input logic signed [VAL_W-1:0] offset);
        logic signed [63:0] s;
        s = scaled(slope, raw);
        s = s + offset;
        return clamp_val(s);
    endfunction

    function automatic void predict_reading(input logic [RAW_W-1:0] raw,
                                            input logic [ELAP_W-1:0] ms);
        t_reading                r;
        logic signed [VAL_W-1:0] corr;
        logic signed [63:0]      p;
        logic signed [63:0]      q;
        logic signed [63:0]      d;
        r.line   = LINE_BASE;
        r.locked = 1'b0;
        if (!tracking) begin
            corr = on_line(cfg_slope_fall, raw, cfg_off_base);
            // a saturated count freezes both sums
            if (n_counted != '1) begin
                raw_total  = raw_total + raw;
                true_total = true_total + corr;
                n_counted  = n_counted + 1'b1;
            end
            if (ms >= cfg_window_ms && n_counted > cfg_min_count) begin
                if (n_counted != '0) begin
                    mean_raw_lk  = RAW_W'(raw_total / n_counted);
                    q            = true_total / $signed({1'b0, n_counted});
                    mean_true_lk = clamp_val(q);
                end else begin
                    mean_raw_lk  = '0;
                    mean_true_lk = '0;
                end
                q = mean_true_lk;
                q = q - scaled(cfg_slope_fall, mean_raw_lk);
                fall_anchor = clamp_val(q);
                q = mean_true_lk;
                q = q - scaled(cfg_slope_rise, mean_raw_lk);
                rise_anchor = clamp_val(q);
                tracking     = 1'b1;
                rising_trend = 1'b0;
                prev_raw     = raw;
                r.locked     = 1'b1;
            end
        end else begin
            p = raw;
            q = prev_raw;
            d = cfg_band;
            // inside the band the previous trend holds
            if (p < q - d)
                rising_trend = 1'b0;
            else if (p > q + d)
                rising_trend = 1'b1;
            if (rising_trend) begin
                corr   = on_line(cfg_slope_rise, raw, rise_anchor);
                r.line = LINE_RISE;
            end else begin
                corr   = on_line(cfg_slope_fall, raw, fall_anchor);
                r.line = LINE_FALL;
            end
            prev_raw = raw;
        end
        r.corrected = corr;
        r.mean_raw  = tracking ? mean_raw_lk : '0;
        r.mean_true = tracking ? mean_true_lk : '0;
        reading_q.push_back(r);
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sending  = 1'b0;
            gap_left = 0;
            s_axis_tvalid <= 1'b0;
        end else begin
            if (sending && s_axis_tready) begin
                predict_reading(cur_sample.raw, cur_sample.ms);
                n_sent++;
                sending  = 1'b0;
                gap_left = calm ? 0 : pick_gap();
            end
            if (!sending) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_q.size() != 0) begin
                    cur_sample = sample_q.pop_front();
                    sending    = 1'b1;
                end
            end
            s_axis_tvalid <= sending;
            s_axis_tdata  <= {1'b0, cur_sample.ms, cur_sample.raw};
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        bit       rdy;
        if (!i_rst_n) begin
            stall_left = 0;
            hold_left  = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.corrected = m_axis_tdata[24:0];
                got.mean_raw  = m_axis_tdata[47:25];
                got.mean_true = m_axis_tdata[72:48];
                got.line      = t_line'(m_axis_tuser[1:0]);
                got.locked    = m_axis_tuser[2];
                n_taken++;
                if (got.locked) n_locks++;
                case (got.line)
                    LINE_BASE: n_base++;
                    LINE_FALL: n_fall++;
                    default:   n_rise++;
                endcase
                if (reading_q.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("ERROR result with none expected: corr %0d line %0d lock %0d",
                                 got.corrected, got.line, got.locked);
                end else begin
                    want = reading_q.pop_front();
                    if (got.corrected !== want.corrected || got.line !== want.line ||
                        got.locked !== want.locked || got.mean_raw !== want.mean_raw ||
                        got.mean_true !== want.mean_true) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("ERROR result %0d: expected corr %0d line %0d lock %0d",
                                     n_taken, want.corrected, want.line, want.locked);
                            $display("      mean_raw %0d mean_true %0d; got corr %0d line %0d",
                                     want.mean_raw, want.mean_true, got.corrected, got.line);
                            $display("      lock %0d mean_raw %0d mean_true %0d",
                                     got.locked, got.mean_raw, got.mean_true);
                        end
                    end
                end
            end
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (calm) begin
                rdy = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                stall_left = pick_gap();
            end
            m_axis_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, reading_q.size());
            $display("FAIL baseline_anchored_trend_calibrator_top");
            $finish;
        end
    end

    task automatic send(input logic [RAW_W-1:0] raw, input logic [ELAP_W-1:0] ms);
        t_sample s;
        s.raw = raw;
        s.ms  = ms;
        sample_q.push_back(s);
    endtask

    // waits until every queued sample is sent and every expected result has been taken
    task automatic drain();
        while (sample_q.size() != 0 || sending || reading_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_SLOPE_FALL: cfg_slope_fall = val[SLOPE_W-1:0];
            CFG_OFF_FALL:   cfg_off_base   = val[OFFB_W-1:0];
            CFG_SLOPE_RISE: cfg_slope_rise = val[SLOPE_W-1:0];
            CFG_DEAD_BAND:  cfg_band       = val[DB_W-1:0];
            CFG_BASE_MS:    cfg_window_ms  = val[BMS_W-1:0];
            CFG_MIN_CNT:    cfg_min_count  = val[MINC_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [RAW_W-1:0] rand_raw();
        if ($urandom_range(0, 6) == 0) return RAW_W'($urandom_range(0, 8388607));
        return RAW_W'($urandom_range(0, 6553600));
    endfunction

    function automatic int rand_offset();
        return int'($urandom_range(0, 13107199)) - 6553600;
    endfunction

    // tracking-phase walk: steps near the deadband edges, steps within twice the band, and jumps
    task automatic random_walk(input int count);
        int p;
        int d;
        int v;
        repeat (count) begin
            p = gen_raw;
            d = cfg_band;
            case ($urandom_range(0, 9))
                0, 1, 2: v = p + ($urandom_range(0, 1) ? 1 : -1) *
                             (d + int'($urandom_range(0, 2)) - 1);
                3, 4, 5: v = p + int'($urandom_range(0, 4 * d + 4)) - 2 * d - 2;
                6, 7, 8: v = $urandom_range(0, 6553600);
                default: v = $urandom_range(0, 8388607);
            endcase
            if (v < 0) v = 0;
            if (v > 8388607) v = 8388607;
            gen_raw = v[RAW_W-1:0];
            send(gen_raw, $urandom);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: too few samples to lock, even at or past the window
        send(23'd0, 32'd0);
        send(23'd6553600, 32'd119999);
        send(23'h7FFFFF, 32'd120000);
        send(23'd1, 32'hFFFFFFFF);
        send(23'd3276800, 32'd5000);
        drain();

        // window open from time zero, but the count can never pass the minimum
        cfg_write(CFG_SLOPE_FALL, 32'd131071);
        cfg_write(CFG_OFF_FALL, 32'd6553599);
        cfg_write(CFG_SLOPE_RISE, 32'd0);
        cfg_write(CFG_DEAD_BAND, 32'd65535);
        cfg_write(CFG_BASE_MS, 32'd0);
        cfg_write(CFG_MIN_CNT, 32'd65535);
        send(23'h7FFFFF, 32'hFFFFFFFF);
        send(23'd6553600, 32'd0);
        send(23'd0, 32'd77);
        drain();

        cfg_write(CFG_SLOPE_FALL, 32'd0);
        cfg_write(CFG_OFF_FALL, -6553600);
        send(23'd4194304, 32'd1);
        send(23'h7FFFFF, 32'd2);
        drain();

        cfg_write(CFG_SLOPE_FALL, 32'd65536);
        cfg_write(CFG_OFF_FALL, 32'h00FFFFFF);
        repeat (150) send(rand_raw(), $urandom);
        drain();

        // baseline run, back to back
        cfg_write(CFG_SLOPE_FALL, $urandom_range(0, 131071));
        cfg_write(CFG_OFF_FALL, rand_offset());
        calm = 1'b1;
        repeat (40) send(rand_raw(), $urandom);
        drain();
        calm = 1'b0;

        // lock at the last tick of the window
        cfg_write(CFG_SLOPE_FALL, 32'd63177);
        cfg_write(CFG_OFF_FALL, 32'd80282);
        cfg_write(CFG_SLOPE_RISE, 32'd69114);
        cfg_write(CFG_DEAD_BAND, 32'd131);
        cfg_write(CFG_BASE_MS, 32'hFFFFFFFF);
        cfg_write(CFG_MIN_CNT, 32'd0);
        send(23'd5000000, 32'hFFFFFFFE);
        send(23'd3000000, 32'hFFFFFFFF);
        // deadband edges: +band holds, +band+1 rises, -band holds, -band-1 falls
        send(23'd3000131, 32'd10);
        send(23'd3000263, 32'd20);
        send(23'd3000132, 32'd30);
        send(23'd3000000, 32'd40);
        send(23'd3000000, 32'd50);
        send(23'h7FFFFF, 32'd60);
        send(23'd0, 32'd70);
        gen_raw = '0;
        drain();

        // offset and window writes no longer matter once locked
        cfg_write(CFG_DEAD_BAND, 32'd0);
        cfg_write(CFG_SLOPE_FALL, 32'd131071);
        cfg_write(CFG_SLOPE_RISE, 32'd131071);
        cfg_write(CFG_OFF_FALL, rand_offset());
        cfg_write(CFG_BASE_MS, $urandom);
        cfg_write(CFG_MIN_CNT, $urandom_range(0, 65535));
        random_walk(320);
        repeat (30) @(posedge i_clk);
        hold_reqs++;
        drain();

        cfg_write(CFG_DEAD_BAND, 32'd65535);
        cfg_write(CFG_SLOPE_FALL, 32'd0);
        cfg_write(CFG_SLOPE_RISE, 32'd0);
        calm = 1'b1;
        random_walk(320);
        drain();
        calm = 1'b0;

        repeat (2) begin
            cfg_write(CFG_DEAD_BAND, $urandom_range(0, 2000));
            cfg_write(CFG_SLOPE_FALL, $urandom_range(0, 131071));
            cfg_write(CFG_SLOPE_RISE, $urandom_range(0, 131071));
            cfg_write(CFG_OFF_FALL, rand_offset());
            random_walk(320);
            drain();
        end

        repeat (150) @(posedge i_clk);
        $display("Ran %0d samples through baseline, saturating lines, lock and tracking;",
                 n_sent);
        $display("%0d results: %0d baseline, %0d falling, %0d rising, %0d lock(s)",
                 n_taken, n_base, n_fall, n_rise, n_locks);
        if (bad_results == 0 && reading_q.size() == 0) begin
            $display("PASS baseline_anchored_trend_calibrator_top");
        end else begin
            $display("%0d bad results, %0d missing", bad_results, reading_q.size());
            $display("FAIL baseline_anchored_trend_calibrator_top");
        end
        $finish;
    end

endmodule
